// ----- hdl/ssd_pkg.sv -----
// ssd_pkg: shared constants, command codes, segment table and item types
// for the seven-segment frame generator. No dependencies.
package ssd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int VALUE_W    = 16;
    localparam int OP_W       = 2;
    localparam int DIG_W      = 4;
    localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int BRIGHT_W   = 3;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

    function automatic int unsigned pow10(input int n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam int unsigned SAT_LIMIT = pow10(NUM_DIGITS) - 1;

    // reciprocal divide by ten, exact for any 16-bit dividend
    localparam int           DIV10_SHIFT = 19;
    localparam int           PROD_W      = VALUE_W + 17;
    localparam logic [16:0]  DIV10_MUL   = 17'd52429;

    localparam logic [OP_W-1:0] OP_SHOW  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_CTRL  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SUPPRESS = 2'd2;

    localparam logic [7:0] DATA_CMD_FIXED = 8'h44;
    localparam logic [7:0] ADDR_CMD_BASE  = 8'hC0;
    localparam logic [7:0] CTRL_CMD_BASE  = 8'h80;

    typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] ssd_digits_t;

    // dig[0] is the most significant position
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] rem;
        ssd_digits_t        dig;
    } ssd_item_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic                display_on;
        logic                zero_suppress;
    } ssd_cfg_t;

    function automatic logic [7:0] seg_of(input logic [DIG_W-1:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/ssd_digit_stage.sv -----
// ssd_digit_stage: one pipeline stage that peels the low decimal digit off
// the remaining value and shifts it into the digit vector. Uses ssd_pkg.
module ssd_digit_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssd_pkg::ssd_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ssd_pkg::ssd_item_t out_item
);

    logic                         valid_reg;
    logic                         valid_next;
    ssd_pkg::ssd_item_t           item_reg;
    ssd_pkg::ssd_item_t           item_next;
    logic [ssd_pkg::PROD_W-1:0]   prod;
    logic [ssd_pkg::VALUE_W-1:0]  quot;
    logic [ssd_pkg::VALUE_W-1:0]  quot10;
    logic [ssd_pkg::VALUE_W-1:0]  rmd;
    logic                         take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        prod   = ssd_pkg::PROD_W'(in_item.rem) * ssd_pkg::PROD_W'(ssd_pkg::DIV10_MUL);
        quot   = ssd_pkg::VALUE_W'(prod >> ssd_pkg::DIV10_SHIFT);
        quot10 = ssd_pkg::VALUE_W'((quot << 3) + (quot << 1));
        rmd    = in_item.rem - quot10;

        item_next     = in_item;
        item_next.rem = quot;
        // older digits move toward the less significant end
        for (int i = ssd_pkg::NUM_DIGITS - 1; i > 0; i--) begin
            item_next.dig[i] = in_item.dig[i-1];
        end
        item_next.dig[0] = rmd[ssd_pkg::DIG_W-1:0];

        if (take) begin
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (item_reg.dig[0] <= ssd_pkg::DIG_W'(9)))
        else $error("digit stage produced a non-decimal digit");

endmodule

// ----- hdl/ssd_frame_seq.sv -----
// ssd_frame_seq: holds one decoded command and walks it out as bus frames,
// one byte per cycle while not stalled, via a registered output. Uses ssd_pkg.
module ssd_frame_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  ssd_pkg::ssd_cfg_t  cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ssd_pkg::ssd_item_t cmd_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         bus_byte,
    output logic               start_before,
    output logic               stop_after,
    output logic               last
);

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_ADDR = 2'd1;
    localparam logic [1:0] PH_SEG  = 2'd2;

    logic                     busy_reg, busy_next;
    logic                     ctrl_reg, ctrl_next;
    logic [1:0]               phase_reg, phase_next;
    logic [ssd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [ssd_pkg::NUM_DIGITS-1:0][7:0] segs_reg, segs_next;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               byte_reg, byte_next;
    logic                     start_reg, start_next;
    logic                     stop_reg, stop_next;
    logic                     last_reg, last_next;

    logic                     out_free;
    logic                     load;
    logic                     fin;
    logic                     take;
    logic [ssd_pkg::POS_W-1:0] first_pos;

    assign out_free  = !out_valid_reg || out_ready;
    assign load      = busy_reg && out_free;
    assign cmd_ready = !busy_reg || (load && fin);
    assign take      = cmd_valid && cmd_ready;

    // frame for the current step
    always_comb
    begin
        byte_next  = byte_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        fin        = 1'b0;
        if (ctrl_reg) begin
            byte_next  = ssd_pkg::CTRL_CMD_BASE | {4'b0000, cfg.display_on, cfg.brightness};
            start_next = 1'b1;
            stop_next  = 1'b1;
            fin        = 1'b1;
        end
        else begin
            case (phase_reg)
                PH_CMD:
                begin
                    byte_next  = ssd_pkg::DATA_CMD_FIXED;
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                end
                PH_ADDR:
                begin
                    byte_next  = ssd_pkg::ADDR_CMD_BASE | 8'(pos_reg);
                    start_next = 1'b1;
                    stop_next  = 1'b0;
                end
                PH_SEG:
                begin
                    byte_next  = segs_reg[pos_reg];
                    start_next = 1'b0;
                    stop_next  = 1'b1;
                    fin        = (pos_reg == ssd_pkg::POS_LAST);
                end
                default:
                begin
                    byte_next  = 8'h00;
                    start_next = 1'b0;
                    stop_next  = 1'b0;
                end
            endcase
        end
        last_next = fin;
    end

    // first written position: most significant nonzero digit when suppressing
    always_comb
    begin
        first_pos = '0;
        if (cmd_item.op == ssd_pkg::OP_SHOW && cfg.zero_suppress) begin
            first_pos = ssd_pkg::POS_LAST;
            for (int i = ssd_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
                if (cmd_item.dig[i] != '0) begin
                    first_pos = ssd_pkg::POS_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        ctrl_next  = ctrl_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        segs_next  = segs_reg;

        if (load) begin
            case (phase_reg)
                PH_CMD:  phase_next = PH_ADDR;
                PH_ADDR: phase_next = PH_SEG;
                PH_SEG:
                begin
                    phase_next = PH_CMD;
                    pos_next   = ssd_pkg::POS_W'(pos_reg + 1'b1);
                end
                default: phase_next = PH_CMD;
            endcase
            if (fin) begin
                busy_next = 1'b0;
            end
        end

        if (take) begin
            busy_next  = (cmd_item.op != ssd_pkg::OP_NONE);
            ctrl_next  = (cmd_item.op == ssd_pkg::OP_CTRL);
            phase_next = PH_CMD;
            pos_next   = first_pos;
            for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
                segs_next[i] = (cmd_item.op == ssd_pkg::OP_SHOW) ?
                               ssd_pkg::seg_of(cmd_item.dig[i]) : 8'h00;
            end
        end

        if (load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= 1'b0;
            phase_reg     <= PH_CMD;
            pos_reg       <= '0;
        end
        else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            ctrl_reg      <= ctrl_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        segs_reg <= segs_next;
        if (load) begin
            byte_reg  <= byte_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bus_byte     = byte_reg;
    assign start_before = start_reg;
    assign stop_after   = stop_reg;
    assign last         = last_reg;

    a_last_has_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> stop_reg)
        else $error("final byte of a command without stop");

    a_addr_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !stop_reg) |-> (start_reg && byte_reg[7:6] == 2'b11))
        else $error("frame without stop is not an address frame");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= ssd_pkg::POS_LAST))
        else $error("digit position out of range");

    a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (load && fin && !take) |=> !busy_reg)
        else $error("sequencer stayed busy after the final frame");

endmodule

// ----- hdl/seven_segment_display_frame_gen_unit.sv -----
// seven_segment_display_frame_gen_unit: top level with config registers,
// input saturation stage, decimal digit pipeline and frame sequencer.
// Depends on ssd_pkg, ssd_digit_stage and ssd_frame_seq.

// Turns show / clear / control commands into bus bytes, one byte per cycle on
// the result channel while not stalled. A show command yields three bytes per
// written digit position (3 to 3*NUM_DIGITS, 12 for all four), a clear command
// always 3*NUM_DIGITS, a control command one, and code 3 none. Commands are
// pipelined through a saturation stage and one stage per decimal digit, and
// the sequencer takes the next command in the same cycle that it loads the
// previous command's last byte. Configuration writes take effect at once.
module seven_segment_display_frame_gen_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ssd_pkg::OP_W-1:0]         operation,
    input  logic [ssd_pkg::VALUE_W-1:0]      value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       bus_byte,
    output logic                             start_before,
    output logic                             stop_after,
    output logic                             last
);

    localparam int ND = ssd_pkg::NUM_DIGITS;

    logic [ssd_pkg::BRIGHT_W-1:0] brightness_reg;
    logic                         display_on_reg;
    logic                         zero_suppress_reg;
    ssd_pkg::ssd_cfg_t            cfg;

    logic                         s0_valid_reg;
    ssd_pkg::ssd_item_t           s0_item_reg;
    ssd_pkg::ssd_item_t           s0_item_next;
    logic [ssd_pkg::VALUE_W-1:0]  sat_value;
    logic                         take;

    logic                         stg_valid [ND+1];
    logic                         stg_ready [ND+1];
    ssd_pkg::ssd_item_t           stg_item  [ND+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            brightness_reg    <= ssd_pkg::BRIGHT_W'(1);
            display_on_reg    <= 1'b1;
            zero_suppress_reg <= 1'b1;
        end
        else if (cfg_we) begin
            case (cfg_index)
                ssd_pkg::REG_BRIGHTNESS:    brightness_reg    <= cfg_data[ssd_pkg::BRIGHT_W-1:0];
                ssd_pkg::REG_DISPLAY_ON:    display_on_reg    <= cfg_data[0];
                ssd_pkg::REG_ZERO_SUPPRESS: zero_suppress_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign cfg.brightness    = brightness_reg;
    assign cfg.display_on    = display_on_reg;
    assign cfg.zero_suppress = zero_suppress_reg;

    // input stage: saturate to the largest value the digits can show
    assign in_ready = !s0_valid_reg || stg_ready[0];
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (32'(value) > ssd_pkg::SAT_LIMIT) begin
            sat_value = ssd_pkg::SAT_LIMIT[ssd_pkg::VALUE_W-1:0];
        end
        else begin
            sat_value = value;
        end
        s0_item_next.op  = operation;
        s0_item_next.rem = sat_value;
        s0_item_next.dig = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end
        else if (take) begin
            s0_valid_reg <= 1'b1;
        end
        else if (stg_ready[0]) begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            s0_item_reg <= s0_item_next;
        end
    end

    assign stg_valid[0] = s0_valid_reg;
    assign stg_item[0]  = s0_item_reg;

    for (genvar g = 0; g < ND; g++) begin : g_digit
        ssd_digit_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    ssd_frame_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (stg_valid[ND]),
        .cmd_ready    (stg_ready[ND]),
        .cmd_item     (stg_item[ND]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bus_byte     (bus_byte),
        .start_before (start_before),
        .stop_after   (stop_after),
        .last         (last)
    );

endmodule
